[src/hfe_pkg.sv]
// Shared constants and types of the Haar feature evaluator.
package hfe_pkg;

  localparam int MAX_DIM  = 64;
  localparam int DIM_W    = $clog2(MAX_DIM);
  localparam int ADDR_W   = 2 * DIM_W;
  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int CFG_W    = 7;
  localparam int ENTRY_W  = 24;
  localparam int WEIGHT_W = 22;
  localparam int SUM_W    = ENTRY_W + 2;
  localparam int ACC_W    = 48;
  localparam int FEAT_W   = 47;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic REG_IMAGE_COLS = 1'b0;
  localparam logic REG_IMAGE_ROWS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_RD_D,
    ST_SUM_D,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } hfe_state_t;

endpackage

[src/haar_feature_evaluator.sv]
// Haar-like feature evaluator over an integral image held in a store with one read port.
//
//   channel   | handshake              | payload
//   ----------+------------------------+------------------------------------------
//   input     | start, busy            | in_operation .. in_last_area
//   result    | out_valid (strobe)     | out_feature_value, out_area_error
//   config    | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// A load transfer writes the store at its accept edge and busy stays low.
// An evaluate transfer keeps busy high through the clamp, four corner reads on the one
// read port, corner sum, multiply and accumulate, or the clamp alone when the origin
// lies outside the image; a last rectangle adds an emit step, its result strobing the
// cycle after. Reset clears state, accumulator and error flag and sets dimensions to 64.
// The receiver cannot stall: out_valid is high for exactly one cycle per result.
module haar_feature_evaluator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_operation,
  input  logic        [hfe_pkg::DIM_W-1:0]      in_row,
  input  logic        [hfe_pkg::DIM_W-1:0]      in_col,
  input  logic        [hfe_pkg::ENTRY_W-1:0]    in_value,
  input  logic        [hfe_pkg::DIM_W-1:0]      in_area_width,
  input  logic        [hfe_pkg::DIM_W-1:0]      in_area_height,
  input  logic signed [hfe_pkg::WEIGHT_W-1:0]   in_area_weight,
  input  logic                                  in_last_area,
  output logic                                  out_valid,
  output logic signed [hfe_pkg::FEAT_W-1:0]     out_feature_value,
  output logic                                  out_area_error,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [hfe_pkg::PADDR_W-1:0]    paddr,
  input  logic        [hfe_pkg::PDATA_W-1:0]    pwdata,
  output logic        [hfe_pkg::PDATA_W-1:0]    prdata,
  output logic                                  pready
);
  import hfe_pkg::*;

  localparam logic [CFG_W-1:0] DIM_MAX_C = CFG_W'(MAX_DIM);
  localparam logic [DIM_W:0]   DIM_RST_C = (DIM_W + 1)'(MAX_DIM);
  localparam logic signed [FEAT_W-1:0] FEAT_MAX = {1'b0, {(FEAT_W - 1){1'b1}}};
  localparam logic signed [FEAT_W-1:0] FEAT_MIN = {1'b1, {(FEAT_W - 1){1'b0}}};

  hfe_state_t state_r, state_nxt;

  logic [CFG_W-1:0] cols_r, rows_r;

  logic [DIM_W-1:0]           x_r, y_r, w_r, h_r, x2_r, y2_r;
  logic signed [WEIGHT_W-1:0] weight_r;
  logic                       last_r;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;

  logic signed [SUM_W-1:0] sum_r;
  logic signed [ACC_W-1:0] prod_r;
  logic [ACC_W-1:0]        acc_r;
  logic                    err_r;

  logic                    out_valid_r;
  logic signed [FEAT_W-1:0] out_feature_value_r;
  logic                    out_area_error_r;

  logic             accept, load_accept, cfg_write;
  logic [CFG_W-1:0] cols_lim, rows_lim, col_last, row_last;
  logic [DIM_W:0]   xw, yh;
  logic             outside;

  logic [ACC_W-1:0] add_a, add_b, add_y;
  logic             add_sub;

  logic signed [SUM_W+WEIGHT_W-1:0] mul_y;

  assign busy        = (state_r != ST_IDLE);
  assign accept      = start && !busy;
  assign load_accept = accept && (in_operation == OP_LOAD);
  assign cfg_write   = psel && penable && pwrite;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IMAGE_ROWS) ? PDATA_W'(rows_r) : PDATA_W'(cols_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CFG_W'(DIM_RST_C);
      rows_r <= CFG_W'(DIM_RST_C);
    end else if (cfg_write) begin
      if (paddr[2] == REG_IMAGE_ROWS) begin
        rows_r <= pwdata[CFG_W-1:0];
      end else begin
        cols_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  // Clamp the far corner to the last column and row of the image.
  assign cols_lim = (cols_r > DIM_MAX_C) ? DIM_MAX_C : cols_r;
  assign rows_lim = (rows_r > DIM_MAX_C) ? DIM_MAX_C : rows_r;
  assign col_last = cols_lim - CFG_W'(1);
  assign row_last = rows_lim - CFG_W'(1);
  assign xw       = {1'b0, x_r} + {1'b0, w_r};
  assign yh       = {1'b0, y_r} + {1'b0, h_r};
  assign outside  = (CFG_W'(x_r) >= cols_lim) || (CFG_W'(y_r) >= rows_lim);

  always_comb begin
    case (state_r)
      ST_RD_A: rd_addr = {y2_r, x2_r};
      ST_RD_B: rd_addr = {y_r, x_r};
      ST_RD_C: rd_addr = {y_r, x2_r};
      ST_RD_D: rd_addr = {y2_r, x_r};
      default: rd_addr = {y_r, x_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_accept) begin
      mem[{in_row, in_col}] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // One adder serves both the corner sum and the accumulator update.
  always_comb begin
    add_a   = ACC_W'(sum_r);
    add_b   = ACC_W'(rd_data_r);
    add_sub = 1'b0;
    case (state_r)
      ST_RD_B: add_a = '0;
      ST_RD_D,
      ST_SUM_D: add_sub = 1'b1;
      ST_ACC: begin
        add_a = acc_r;
        add_b = prod_r;
      end
      default: add_sub = 1'b0;
    endcase
  end

  assign add_y = add_a + (add_b ^ {ACC_W{add_sub}}) + ACC_W'(add_sub);
  assign mul_y = sum_r * weight_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_operation == OP_EVAL)) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (!outside) begin
          state_nxt = ST_RD_A;
        end else if (last_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_A:  state_nxt = ST_RD_B;
      ST_RD_B:  state_nxt = ST_RD_C;
      ST_RD_C:  state_nxt = ST_RD_D;
      ST_RD_D:  state_nxt = ST_SUM_D;
      ST_SUM_D: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r      <= in_col;
      y_r      <= in_row;
      w_r      <= in_area_width;
      h_r      <= in_area_height;
      weight_r <= in_area_weight;
      last_r   <= in_last_area;
    end
    if (state_r == ST_CLAMP) begin
      x2_r <= (CFG_W'(xw) >= col_last) ? col_last[DIM_W-1:0] : xw[DIM_W-1:0];
      y2_r <= (CFG_W'(yh) >= row_last) ? row_last[DIM_W-1:0] : yh[DIM_W-1:0];
    end
    case (state_r)
      ST_RD_B,
      ST_RD_C,
      ST_RD_D,
      ST_SUM_D: sum_r <= add_y[SUM_W-1:0];
      ST_MUL:   prod_r <= ACC_W'(mul_y);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if ((state_r == ST_CLAMP) && outside) begin
        err_r <= 1'b1;
      end
      if (state_r == ST_ACC) begin
        acc_r <= add_y;
      end
      if (state_r == ST_EMIT) begin
        out_valid_r <= 1'b1;
        acc_r       <= '0;
        err_r       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      out_area_error_r <= err_r;
      if (acc_r[ACC_W-1] != acc_r[ACC_W-2]) begin
        out_feature_value_r <= acc_r[ACC_W-1] ? FEAT_MIN : FEAT_MAX;
      end else begin
        out_feature_value_r <= acc_r[FEAT_W-1:0];
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_feature_value = out_feature_value_r;
  assign out_area_error    = out_area_error_r;

  a_result_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_EMIT)
    else $error("A result appeared without an emit step.");

  a_cleared_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (acc_r == '0) && !err_r)
    else $error("The accumulator or error flag was not cleared with the result.");

  a_eval_enters_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_operation == OP_EVAL)) |=> state_r == ST_CLAMP)
    else $error("An evaluate transfer did not start the sequence.");

  a_mul_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> $past(state_r) == ST_SUM_D)
    else $error("The multiply step ran before the corner sum was complete.");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_accept |=> !busy)
    else $error("A load transfer made the block busy.");

endmodule
